FILE: design/pes_pkg.sv
// Shared types and constants for the product-except-self block.
// Payload structs for both channels and the sequencer states.
// No dependencies.
package pes_pkg;

	localparam int unsigned DATA_W = 32;

	localparam logic [DATA_W-1:0] ONE = 32'd1;

	typedef struct packed {
		logic signed [DATA_W-1:0] value;
		logic                     last;
	} in_word_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] product;
		logic                     last_out;
	} out_word_t;

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_BACK,
		ST_FWD_RD,
		ST_FWD_CALC
	} state_t;

endpackage

FILE: design/pes_ram.sv
// Single-port-write, single-port-read synchronous RAM with a registered read.
// Read data holds until the next read is issued.
// No package dependencies.
module pes_ram #(
	parameter int unsigned DEPTH = 64,
	parameter int unsigned WIDTH = 32,
	parameter int unsigned AW    = 6
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: design/product_except_self_core.sv
// Top level of the product-except-self block: load, suffix pass, emit pass.
// Depends on pes_pkg (types, states) and pes_ram (element and suffix stores).
//
//   channel | dir | handshake                   | word
//   --------+-----+-----------------------------+------------------------------
//   item    | in  | item_valid / item_ready     | pes_pkg::in_word_t  (value, last)
//   result  | out | result_valid / result_ready | pes_pkg::out_word_t (product, last_out)
//
// Loading takes one element per cycle while item_ready is high. On the closing
// element (last set, or the store full) the suffix pass runs, one element store
// read and one 32x32 multiply per cycle; the emit pass then handles each result
// as a memory read, then two parallel multiplies, one into the output register
// and one into the running prefix product.
// Reset clears the sequencer, counters and output valid; the stores are not cleared.
// A stall on result holds the emit pass in its calc step; item_ready is high
// only while loading, also while the final result still waits in its register.
module product_except_self_core #(
	parameter int unsigned MAX_ELEMENTS = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_ready,
	input  pes_pkg::in_word_t  item,
	output logic               result_valid,
	input  logic               result_ready,
	output pes_pkg::out_word_t result
);

	localparam int unsigned CNT_W = $clog2(MAX_ELEMENTS + 1);
	localparam int unsigned IDX_W = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
	localparam int unsigned DW    = pes_pkg::DATA_W;

	// sequencer and control
	pes_pkg::state_t state_q, state_d;
	logic [CNT_W-1:0] count_q;      // elements loaded in the current set
	logic [IDX_W-1:0] last_idx_q;   // index of the closing element
	logic [IDX_W-1:0] idx_q;        // read pointer for both passes
	logic             iss_q;        // suffix pass still issuing reads
	logic [IDX_W-1:0] addr_s1;      // address of the read now returning
	logic             vld_s1;       // a suffix-pass read returns this cycle

	// datapath
	logic [DW-1:0] acc_q;           // running suffix product
	logic [DW-1:0] prefix_q;        // running prefix product
	logic [DW-1:0] product_q;
	logic          last_out_q;
	logic          out_valid_q;

	// store ports
	logic             elem_we, elem_re, suf_we, suf_re;
	logic [IDX_W-1:0] elem_waddr, elem_raddr;
	logic [DW-1:0]    elem_rdata, suf_rdata;

	// decoded strobes
	logic in_acc, closing, out_free, emit;

	assign in_acc   = item_valid && item_ready;
	assign closing  = item.last || (count_q == CNT_W'(MAX_ELEMENTS - 1));
	assign out_free = !out_valid_q || result_ready;

	// element store: written on load, read in both passes
	pes_ram #(
		.DEPTH(MAX_ELEMENTS),
		.WIDTH(DW),
		.AW   (IDX_W)
	) u_elem_ram (
		.clk  (clk),
		.we   (elem_we),
		.waddr(elem_waddr),
		.wdata(item.value),
		.re   (elem_re),
		.raddr(elem_raddr),
		.rdata(elem_rdata)
	);

	// suffix store: written in the backward pass, read in the emit pass
	pes_ram #(
		.DEPTH(MAX_ELEMENTS),
		.WIDTH(DW),
		.AW   (IDX_W)
	) u_suf_ram (
		.clk  (clk),
		.we   (suf_we),
		.waddr(addr_s1),
		.wdata(acc_q),
		.re   (suf_re),
		.raddr(idx_q),
		.rdata(suf_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pes_pkg::ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and store strobes
	always_comb begin
		state_d    = state_q;
		item_ready = 1'b0;
		elem_we    = 1'b0;
		elem_waddr = count_q[IDX_W-1:0];
		elem_re    = 1'b0;
		elem_raddr = idx_q;
		suf_we     = 1'b0;
		suf_re     = 1'b0;
		emit       = 1'b0;
		case (state_q)
			pes_pkg::ST_LOAD: begin
				item_ready = 1'b1;
				elem_we    = item_valid;
				if (item_valid && closing) begin
					state_d = pes_pkg::ST_BACK;
				end
			end
			pes_pkg::ST_BACK: begin
				elem_re = iss_q;
				suf_we  = vld_s1;
				if (vld_s1 && (addr_s1 == '0)) begin
					state_d = pes_pkg::ST_FWD_RD;
				end
			end
			pes_pkg::ST_FWD_RD: begin
				elem_re = 1'b1;
				suf_re  = 1'b1;
				state_d = pes_pkg::ST_FWD_CALC;
			end
			pes_pkg::ST_FWD_CALC: begin
				if (out_free) begin
					emit    = 1'b1;
					state_d = (idx_q == last_idx_q) ? pes_pkg::ST_LOAD : pes_pkg::ST_FWD_RD;
				end
			end
			default: begin
				state_d = pes_pkg::ST_LOAD;
			end
		endcase
	end

	// counters and pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			last_idx_q <= '0;
			idx_q      <= '0;
			iss_q      <= 1'b0;
			vld_s1     <= 1'b0;
			addr_s1    <= '0;
		end else begin
			case (state_q)
				pes_pkg::ST_LOAD: begin
					if (in_acc) begin
						if (closing) begin
							// start the backward pass at the closing element
							count_q    <= '0;
							last_idx_q <= count_q[IDX_W-1:0];
							idx_q      <= count_q[IDX_W-1:0];
							iss_q      <= 1'b1;
						end else begin
							count_q <= count_q + CNT_W'(1);
						end
					end
				end
				pes_pkg::ST_BACK: begin
					// mark a returning read in the cycle after each issue
					vld_s1 <= iss_q;
					if (iss_q) begin
						addr_s1 <= idx_q;
						if (idx_q == '0) begin
							iss_q <= 1'b0;
						end else begin
							idx_q <= idx_q - IDX_W'(1);
						end
					end
				end
				pes_pkg::ST_FWD_CALC: begin
					if (emit && (idx_q != last_idx_q)) begin
						idx_q <= idx_q + IDX_W'(1);
					end
				end
				default: begin
				end
			endcase
		end
	end

	// running products: one multiply per register
	always_ff @(posedge clk) begin
		if (in_acc && closing) begin
			acc_q <= pes_pkg::ONE;
		end else if ((state_q == pes_pkg::ST_BACK) && vld_s1) begin
			acc_q <= acc_q * elem_rdata;
		end
		if ((state_q == pes_pkg::ST_BACK) && vld_s1 && (addr_s1 == '0)) begin
			prefix_q <= pes_pkg::ONE;
		end else if (emit) begin
			prefix_q <= prefix_q * elem_rdata;
		end
		if (emit) begin
			product_q  <= prefix_q * suf_rdata;
			last_out_q <= (idx_q == last_idx_q);
		end
	end

	// output register: load on emit, drop on acceptance
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign result_valid    = out_valid_q;
	assign result.product  = product_q;
	assign result.last_out = last_out_q;

endmodule
